>>> src/trp_pkg.sv
package trp_pkg;

  // Sample and datapath widths
  localparam int SMP_W      = 16;
  localparam int PRE_SH     = 15;
  localparam int XY_W       = 34;
  localparam int ACC_W      = 34;
  localparam int ANG_W      = 33;
  localparam int TAB_LEN    = 24;

  // Square root of (y^2 + z^2) * 2^30: 32-bit radicand, 31 root bits
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = 31;
  localparam int REM_W      = 32;
  localparam int SQRT_STEPS = 31;

  // Binary angle to degrees * 128
  localparam int FRAC_SH    = 32;
  localparam int PROD_W     = ANG_W + 16;
  localparam int DEGQ_W     = PROD_W - FRAC_SH;
  localparam int DEGD_W     = DEGQ_W + 1;
  localparam int ROLL_W     = 16;
  localparam int PITCH_W    = 15;
  localparam int ROLL_LIMIT  = 23040;
  localparam int PITCH_LIMIT = 11520;

  localparam logic signed [ACC_W-1:0] HALF_TURN  = 34'sh0_8000_0000;
  localparam logic [15:0]             DEG_SCALE  = 16'd46080;
  localparam logic [PROD_W-1:0]       ROUND_HALF = 49'h0_0000_8000_0000;
  localparam logic signed [DEGD_W-1:0] DEG_OFF   = 18'sd23040;

  // Half-turn pre-rotation applied before the iterations
  typedef enum logic [1:0] {
    TURN_NONE,
    TURN_POS,
    TURN_NEG
  } turn_t;

  typedef struct packed {
    logic  zero;
    turn_t turn;
  } cordic_ctl_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] ax;
    logic signed [SMP_W-1:0] ay;
    logic signed [SMP_W-1:0] az;
  } sample_t;

  // atan(2^-i) in units of 2^-32 turn, rounded
  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/trp_sqrt.sv
module trp_sqrt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [trp_pkg::SMP_W-1:0]    in_a,
  input  logic signed [trp_pkg::SMP_W-1:0]    in_b,
  output logic                                out_vld,
  output logic [trp_pkg::ROOT_W-1:0]          out_root
);

  localparam int STEPS  = trp_pkg::SQRT_STEPS;
  localparam int RAD_W  = trp_pkg::RAD_W;
  localparam int ROOT_W = trp_pkg::ROOT_W;
  localparam int REM_W  = trp_pkg::REM_W;
  localparam int SMP_W  = trp_pkg::SMP_W;

  logic signed [2*SMP_W-1:0] a_prod;
  logic signed [2*SMP_W-1:0] b_prod;
  logic [RAD_W-1:0]          a_sq_r;
  logic [RAD_W-1:0]          b_sq_r;
  logic                      sq_vld_r;

  logic                      vld_r  [STEPS+1];
  logic [RAD_W-1:0]          rad_r  [STEPS];
  logic [REM_W-1:0]          rem_r  [STEPS];
  logic [ROOT_W-1:0]         root_r [STEPS+1];

  assign a_prod = in_a * in_a;
  assign b_prod = in_b * in_b;

  always_ff @(posedge clk) begin
    if (en) begin
      a_sq_r    <= RAD_W'(unsigned'(a_prod));
      b_sq_r    <= RAD_W'(unsigned'(b_prod));
      rad_r[0]  <= a_sq_r + b_sq_r;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r <= in_vld;
      vld_r[0] <= sq_vld_r;
    end
  end

  // One root bit per stage; the low radicand pairs shift in as zeros
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W+1:0]  rem_dif;
    logic [ROOT_W-1:0] root_nxt;

    assign rem_sh   = {rem_r[k], rad_r[k][RAD_W-1 -: 2]};
    assign trial    = (REM_W+2)'({root_r[k], 2'b01});
    assign ge       = (rem_sh >= trial);
    assign rem_dif  = ge ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {root_r[k][ROOT_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k+1] <= root_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    if (k < STEPS-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= REM_W'(rem_dif);
          rad_r[k+1] <= {rad_r[k][RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign out_root = root_r[STEPS];

  // sqrt(2 * 2^60) is the largest root a full-scale sample pair can give
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (out_root <= 31'd1518500249))
    else $error("yz magnitude out of range");

endmodule

>>> src/trp_cordic.sv
module trp_cordic #(
  parameter int STAGES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [trp_pkg::XY_W-1:0]    in_y,
  input  logic signed [trp_pkg::XY_W-1:0]    in_x,
  output logic                               out_vld,
  output logic signed [trp_pkg::ANG_W-1:0]   out_angle
);

  localparam int ITER  = (STAGES < trp_pkg::TAB_LEN) ? STAGES : trp_pkg::TAB_LEN;
  localparam int XY_W  = trp_pkg::XY_W;
  localparam int ACC_W = trp_pkg::ACC_W;
  localparam int ANG_W = trp_pkg::ANG_W;

  logic                      vld_r [ITER+1];
  trp_pkg::cordic_ctl_t      ctl_r [ITER+1];
  logic signed [XY_W-1:0]    x_r   [ITER];
  logic signed [XY_W-1:0]    y_r   [ITER];
  logic signed [ACC_W-1:0]   acc_r [ITER+1];

  trp_pkg::cordic_ctl_t      ctl_nxt;
  logic                      x_neg;

  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   sum;
  logic signed [ACC_W-1:0]   ang;
  logic signed [ANG_W-1:0]   angle_r;
  logic                      out_vld_r;

  // Fold the left half-plane onto the right by a half turn
  always_comb begin
    x_neg        = in_x < 0;
    ctl_nxt.zero = (in_y == '0);
    if (in_y == '0) begin
      ctl_nxt.turn = x_neg ? trp_pkg::TURN_POS : trp_pkg::TURN_NONE;
    end else if (x_neg) begin
      ctl_nxt.turn = (in_y > 0) ? trp_pkg::TURN_POS : trp_pkg::TURN_NEG;
    end else begin
      ctl_nxt.turn = trp_pkg::TURN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_nxt;
      x_r[0]   <= x_neg ? -in_x : in_x;
      y_r[0]   <= x_neg ? -in_y : in_y;
      acc_r[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  for (genvar k = 0; k < ITER; k++) begin : g_iter
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [ACC_W-1:0] step;
    logic                    pos;

    assign xs   = x_r[k] >>> k;
    assign ys   = y_r[k] >>> k;
    assign step = ACC_W'(trp_pkg::atan_tab(5'(k)));
    assign pos  = y_r[k] > 0;

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k+1] <= pos ? (acc_r[k] + step) : (acc_r[k] - step);
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    if (k < ITER-1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k+1] <= pos ? (x_r[k] + ys) : (x_r[k] - ys);
          y_r[k+1] <= pos ? (y_r[k] - xs) : (y_r[k] + xs);
        end
      end
    end
  end

  // Add back the half turn, then clamp the residual overshoot; a zero y gives the half turn or zero exactly
  always_comb begin
    case (ctl_r[ITER].turn)
      trp_pkg::TURN_POS: base = trp_pkg::HALF_TURN;
      trp_pkg::TURN_NEG: base = -trp_pkg::HALF_TURN;
      default:           base = '0;
    endcase
    sum = acc_r[ITER] + base;
    if (ctl_r[ITER].zero) begin
      ang = base;
    end else if (sum > trp_pkg::HALF_TURN) begin
      ang = trp_pkg::HALF_TURN;
    end else if (sum < -trp_pkg::HALF_TURN) begin
      ang = -trp_pkg::HALF_TURN;
    end else begin
      ang = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= ANG_W'(ang);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[ITER];
    end
  end

  assign out_vld   = out_vld_r;
  assign out_angle = angle_r;

endmodule

>>> src/trp_deg.sv
module trp_deg #(
  parameter int LIMIT = 23040,
  parameter int OUT_W = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic signed [trp_pkg::ANG_W-1:0]   in_angle,
  output logic                               out_vld,
  output logic signed [OUT_W-1:0]            out_deg
);

  localparam int ANG_W  = trp_pkg::ANG_W;
  localparam int ACC_W  = trp_pkg::ACC_W;
  localparam int PROD_W = trp_pkg::PROD_W;
  localparam int DEGQ_W = trp_pkg::DEGQ_W;
  localparam int DEGD_W = trp_pkg::DEGD_W;
  localparam logic signed [DEGD_W-1:0] LIM = DEGD_W'(LIMIT);

  logic [ACC_W-1:0]         u_sum;
  logic [ANG_W-1:0]         u_r;
  logic [PROD_W-1:0]        p_r;
  logic [PROD_W-1:0]        t;
  logic signed [DEGD_W-1:0] d;
  logic signed [DEGD_W-1:0] d_clamp;
  logic signed [OUT_W-1:0]  deg_r;
  logic [2:0]               vld_r;

  // Offset to 0..2^32, scale by 46080, round half up at bit 32
  assign u_sum = unsigned'(ACC_W'(in_angle) + trp_pkg::HALF_TURN);
  assign t     = p_r + trp_pkg::ROUND_HALF;
  assign d     = signed'({1'b0, t[PROD_W-1 -: DEGQ_W]}) - trp_pkg::DEG_OFF;

  always_comb begin
    if (d > LIM) begin
      d_clamp = LIM;
    end else if (d < -LIM) begin
      d_clamp = -LIM;
    end else begin
      d_clamp = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r   <= ANG_W'(u_sum);
      p_r   <= PROD_W'(u_r) * PROD_W'(trp_pkg::DEG_SCALE);
      deg_r <= OUT_W'(d_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  assign out_vld = vld_r[2];
  assign out_deg = deg_r;

endmodule

>>> src/tilt_roll_pitch_angles.sv
// Channel   Direction  Handshake           Beat payload
// in_       sink       in_valid/in_stall   in_accel_x, in_accel_y, in_accel_z
// out_      source     out_valid/out_stall out_roll_angle, out_pitch_angle
//
// One beat per cycle in and out while the output is not stalled. The stages,
// in order: one input register, the squares and the 31-step yz square root,
// two CORDIC vectoring pipelines run side by side, the degree conversion and
// one output register.
// Reset (rst_n low, synchronous) clears every valid bit; data is not reset.
// A stalled output beat freezes the whole pipeline and raises in_stall.
module tilt_roll_pitch_angles #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [trp_pkg::SMP_W-1:0]     in_accel_x,
  input  logic signed [trp_pkg::SMP_W-1:0]     in_accel_y,
  input  logic signed [trp_pkg::SMP_W-1:0]     in_accel_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [trp_pkg::ROLL_W-1:0]    out_roll_angle,
  output logic signed [trp_pkg::PITCH_W-1:0]   out_pitch_angle
);

  localparam int SMP_W = trp_pkg::SMP_W;
  localparam int XY_W  = trp_pkg::XY_W;
  localparam int EXT_SH = SMP_W - SAMPLE_WIDTH;
  localparam int DLY   = trp_pkg::SQRT_STEPS + 2;

  logic                               en;
  logic                               in_vld_r;
  trp_pkg::sample_t                   smp_r;
  trp_pkg::sample_t                   dly_r [DLY];

  logic                               mag_vld;
  logic [trp_pkg::ROOT_W-1:0]         mag;

  logic signed [XY_W-1:0]             roll_y;
  logic signed [XY_W-1:0]             roll_x;
  logic signed [XY_W-1:0]             pitch_y;
  logic signed [XY_W-1:0]             pitch_x;

  logic                               roll_ang_vld;
  logic                               pitch_ang_vld;
  logic signed [trp_pkg::ANG_W-1:0]   roll_ang;
  logic signed [trp_pkg::ANG_W-1:0]   pitch_ang;

  logic                               roll_deg_vld;
  logic                               pitch_deg_vld;
  logic signed [trp_pkg::ROLL_W-1:0]  roll_deg;
  logic signed [trp_pkg::PITCH_W-1:0] pitch_deg;

  logic                               out_valid_r;
  logic signed [trp_pkg::ROLL_W-1:0]  out_roll_r;
  logic signed [trp_pkg::PITCH_W-1:0] out_pitch_r;

  function automatic logic signed [SMP_W-1:0] sext(input logic [SMP_W-1:0] raw);
    logic [SMP_W-1:0] up;
    up = raw << EXT_SH;
    return signed'(up) >>> EXT_SH;
  endfunction

  function automatic logic signed [XY_W-1:0] prescale(input logic signed [SMP_W-1:0] v);
    return {{(XY_W-SMP_W-trp_pkg::PRE_SH){v[SMP_W-1]}}, v, {trp_pkg::PRE_SH{1'b0}}};
  endfunction

  // Advance everything unless a finished beat sits stalled at the output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (en) begin
      smp_r.ax <= sext(in_accel_x);
      smp_r.ay <= sext(in_accel_y);
      smp_r.az <= sext(in_accel_z);
      dly_r[0] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_valid;
    end
  end

  // Hold the samples alongside the square root
  for (genvar k = 1; k < DLY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  trp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_vld_r),
    .in_a     (smp_r.ay),
    .in_b     (smp_r.az),
    .out_vld  (mag_vld),
    .out_root (mag)
  );

  assign roll_y  = prescale(dly_r[DLY-1].ay);
  assign roll_x  = prescale(dly_r[DLY-1].az);
  assign pitch_y = -prescale(dly_r[DLY-1].ax);
  assign pitch_x = XY_W'(mag);

  trp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (mag_vld),
    .in_y      (roll_y),
    .in_x      (roll_x),
    .out_vld   (roll_ang_vld),
    .out_angle (roll_ang)
  );

  trp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (mag_vld),
    .in_y      (pitch_y),
    .in_x      (pitch_x),
    .out_vld   (pitch_ang_vld),
    .out_angle (pitch_ang)
  );

  trp_deg #(
    .LIMIT (trp_pkg::ROLL_LIMIT),
    .OUT_W (trp_pkg::ROLL_W)
  ) u_deg_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (roll_ang_vld),
    .in_angle (roll_ang),
    .out_vld  (roll_deg_vld),
    .out_deg  (roll_deg)
  );

  trp_deg #(
    .LIMIT (trp_pkg::PITCH_LIMIT),
    .OUT_W (trp_pkg::PITCH_W)
  ) u_deg_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (pitch_ang_vld),
    .in_angle (pitch_ang),
    .out_vld  (pitch_deg_vld),
    .out_deg  (pitch_deg)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_roll_r  <= roll_deg;
      out_pitch_r <= pitch_deg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= roll_deg_vld;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = out_roll_r;
  assign out_pitch_angle = out_pitch_r;

  a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (roll_ang_vld == pitch_ang_vld) && (roll_deg_vld == pitch_deg_vld))
    else $error("roll and pitch pipelines out of step");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_roll_angle <= 16'sd23040) && (out_roll_angle >= -16'sd23040)))
    else $error("roll beyond half turn");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pitch_angle <= 15'sd11520) && (out_pitch_angle >= -15'sd11520)))
    else $error("pitch beyond quarter turn");

endmodule
